### rtl/mcg_pkg.sv
`default_nettype none

package mcg_pkg;

  // fixed configuration of the generator
  localparam int unsigned PULSES_PER_BEAT = 24;
  localparam int unsigned FRACTION_BITS   = 16;

  // field widths
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned ELAPSED_W  = 8;
  localparam int unsigned TEMPO_IN_W = 16;
  localparam int unsigned KIND_W     = 2;

  // internal widths
  localparam int unsigned TEMPO_W  = 15;
  localparam int unsigned PERIOD_W = 25;
  localparam int unsigned WAIT_W   = 26;

  localparam logic [TEMPO_W-1:0] TEMPO_MIN   = TEMPO_W'(1000);
  localparam logic [TEMPO_W-1:0] TEMPO_MAX   = TEMPO_W'(30000);
  localparam logic [TEMPO_W-1:0] TEMPO_RESET = TEMPO_W'(12000);

  // 60000 ms x 100 centi per beat, spread over the pulses of a beat, in fixed point
  localparam longint unsigned NUMER  = longint'(6000000 / PULSES_PER_BEAT) << FRACTION_BITS;
  localparam int unsigned     NUM_W  = $clog2(NUMER + 1);
  localparam int unsigned     CNT_W  = $clog2(NUM_W);

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(NUMER / 12000);

  // shared adder width: covers the wait, the scaled elapsed time and the divider
  localparam int unsigned ALU_W =
    ((WAIT_W > ELAPSED_W + FRACTION_BITS) ? WAIT_W : ELAPSED_W + FRACTION_BITS) + 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK         = 3'd0,
    CMD_START        = 3'd1,
    CMD_CONTINUE     = 3'd2,
    CMD_STOP         = 3'd3,
    CMD_STOP_KEEP    = 3'd4,
    CMD_START_CLOCKS = 3'd5,
    CMD_SET_TEMPO    = 3'd6
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    MSG_CLOCK    = 2'd0,
    MSG_START    = 2'd1,
    MSG_CONTINUE = 2'd2,
    MSG_STOP     = 2'd3
  } msg_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  function automatic logic [TEMPO_W-1:0] clamp_tempo(input logic [TEMPO_IN_W-1:0] t);
    logic [TEMPO_W-1:0] r;
    if (t < TEMPO_IN_W'(TEMPO_MIN)) begin
      r = TEMPO_MIN;
    end else if (t > TEMPO_IN_W'(TEMPO_MAX)) begin
      r = TEMPO_MAX;
    end else begin
      r = t[TEMPO_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/mcg_in_if.sv
`default_nettype none

interface mcg_in_if;
  import mcg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      command;
  logic [ELAPSED_W-1:0]  elapsed_ms;
  logic [TEMPO_IN_W-1:0] tempo_centi_bpm;

  modport source (output valid, output command, output elapsed_ms, output tempo_centi_bpm,
                  input ready);
  modport sink   (input valid, input command, input elapsed_ms, input tempo_centi_bpm,
                  output ready);
endinterface

`default_nettype wire

### rtl/mcg_out_if.sv
`default_nettype none

interface mcg_out_if;
  import mcg_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] message_kind;
  logic              late_warning;

  modport source (output valid, output message_kind, output late_warning, input ready);
  modport sink   (input valid, input message_kind, input late_warning, output ready);
endinterface

`default_nettype wire

### rtl/mcg_alu.sv
`default_nettype none

module mcg_alu (
  input  wire logic signed [mcg_pkg::ALU_W-1:0] a_i,
  input  wire logic signed [mcg_pkg::ALU_W-1:0] b_i,
  input  wire mcg_pkg::alu_op_e                 op_i,
  output logic signed      [mcg_pkg::ALU_W-1:0] y_o
);
  import mcg_pkg::*;

  always_comb begin
    case (op_i)
      ALU_ADD: y_o = a_i + b_i;
      ALU_SUB: y_o = a_i - b_i;
      default: y_o = a_i;
    endcase
  end

endmodule

`default_nettype wire

### rtl/midi_clock_generator.sv
`default_nettype none

// channel  | dir | transaction payload
// ---------+-----+------------------------------------------------
// in_i     | in  | command, elapsed_ms, tempo_centi_bpm
// out_o    | out | message_kind, late_warning
//
// transport commands and a tick while stopped complete in the idle state
// a running tick goes tick, add, then emit if a clock is due; transport skips add
// a set tempo while stopped, or a tick applying a deferred tempo, adds
// restoring division of NUM_W (34) bits, one quotient bit per cycle on the adder
// reset puts the control state at its initial values at once, no clearing pass
// a tick with a result waits in the emit step while the output register is full

module midi_clock_generator (
  input wire logic clk_i,
  input wire logic rst_ni,
  mcg_in_if.sink   in_i,
  mcg_out_if.source out_o
);
  import mcg_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_TICK = 5'b00100,
    ST_ADD  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  localparam logic signed [ALU_W-1:0] WAIT_FLOOR = ALU_W'(-(64'sd1 <<< (WAIT_W - 1)));

  state_e state_q, state_d;

  // transport state
  logic running_q, running_d;
  logic want_start_q, want_start_d;
  logic want_continue_q, want_continue_d;
  logic want_stop_q, want_stop_d;
  logic stop_halts_q, stop_halts_d;
  logic want_first_q, want_first_d;
  logic never_ticked_q, never_ticked_d;
  logic late_seen_q, late_seen_d;

  // tempo and countdown
  logic                      tempo_deferred_q, tempo_deferred_d;
  logic [TEMPO_W-1:0]        deferred_tempo_q, deferred_tempo_d;
  logic [TEMPO_W-1:0]        current_tempo_q, current_tempo_d;
  logic [PERIOD_W-1:0]       pulse_period_q, pulse_period_d;
  logic signed [WAIT_W-1:0]  pulse_wait_q, pulse_wait_d;
  logic [ELAPSED_W-1:0]      elapsed_q, elapsed_d;

  // divider working registers
  logic                      div_for_tick_q, div_for_tick_d;
  logic [NUM_W-1:0]          num_q, num_d;
  logic [TEMPO_W-1:0]        rem_q, rem_d;
  logic [PERIOD_W-1:0]       quot_q, quot_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic              late_q, late_d;
  logic [KIND_W-1:0] pend_kind_q, pend_kind_d;
  logic              pend_late_q, pend_late_d;

  // shared adder
  logic signed [ALU_W-1:0] alu_a, alu_b, alu_y;
  alu_op_e                 alu_op;

  logic [TEMPO_W:0] div_shift;
  logic             busy;
  logic             in_fire;
  logic             slot_free;

  mcg_alu u_alu (
    .a_i  (alu_a),
    .b_i  (alu_b),
    .op_i (alu_op),
    .y_o  (alu_y)
  );

  assign div_shift = {rem_q, num_q[NUM_W-1]};
  assign busy      = want_start_q | want_continue_q | want_stop_q;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire   = in_i.valid & in_i.ready;
  assign slot_free = ~out_valid_q | out_o.ready;

  assign out_o.valid        = out_valid_q;
  assign out_o.message_kind = kind_q;
  assign out_o.late_warning = late_q;

  // operand selection for the shared adder
  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_op = ALU_SUB;
    case (state_q)
      ST_DIV: begin
        alu_a  = ALU_W'(div_shift);
        alu_b  = ALU_W'(current_tempo_q);
        alu_op = ALU_SUB;
      end
      ST_TICK: begin
        alu_a  = ALU_W'(pulse_wait_q);
        alu_b  = ALU_W'(elapsed_q) <<< FRACTION_BITS;
        alu_op = ALU_SUB;
      end
      ST_ADD: begin
        alu_a  = ALU_W'(pulse_wait_q);
        alu_b  = ALU_W'(pulse_period_q);
        alu_op = ALU_ADD;
      end
      default: begin
        alu_a  = '0;
        alu_b  = '0;
        alu_op = ALU_SUB;
      end
    endcase
  end

  always_comb begin
    state_d          = state_q;
    running_d        = running_q;
    want_start_d     = want_start_q;
    want_continue_d  = want_continue_q;
    want_stop_d      = want_stop_q;
    stop_halts_d     = stop_halts_q;
    want_first_d     = want_first_q;
    never_ticked_d   = never_ticked_q;
    late_seen_d      = late_seen_q;
    tempo_deferred_d = tempo_deferred_q;
    deferred_tempo_d = deferred_tempo_q;
    current_tempo_d  = current_tempo_q;
    pulse_period_d   = pulse_period_q;
    pulse_wait_d     = pulse_wait_q;
    elapsed_d        = elapsed_q;
    div_for_tick_d   = div_for_tick_q;
    num_d            = num_q;
    rem_d            = rem_q;
    quot_d           = quot_q;
    cnt_d            = cnt_q;
    pend_kind_d      = pend_kind_q;
    pend_late_d      = pend_late_q;
    out_valid_d      = out_valid_q;
    kind_d           = kind_q;
    late_d           = late_q;

    // output register drains independently of the sequencer
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_i.command)
            CMD_TICK: begin
              if (running_q) begin
                elapsed_d = in_i.elapsed_ms;
                if (never_ticked_q) begin
                  // first tick while running forces a clock, time is ignored
                  if (!want_first_q && !busy) begin
                    want_first_d = 1'b1;
                  end
                  never_ticked_d = 1'b0;
                  elapsed_d      = '0;
                end
                if (tempo_deferred_q) begin
                  current_tempo_d = deferred_tempo_q;
                  div_for_tick_d  = 1'b1;
                  num_d           = NUM_W'(NUMER);
                  rem_d           = '0;
                  quot_d          = '0;
                  cnt_d           = '0;
                  state_d         = ST_DIV;
                end else begin
                  state_d = ST_TICK;
                end
              end
            end
            CMD_START, CMD_CONTINUE: begin
              if (!busy) begin
                if (in_i.command == CMD_START) begin
                  want_start_d = 1'b1;
                end else begin
                  want_continue_d = 1'b1;
                end
                if (!running_q) begin
                  running_d        = 1'b1;
                  tempo_deferred_d = 1'b0;
                end
              end
            end
            CMD_STOP, CMD_STOP_KEEP: begin
              if (!busy && running_q) begin
                want_stop_d  = 1'b1;
                stop_halts_d = (in_i.command == CMD_STOP);
              end
            end
            CMD_START_CLOCKS: begin
              if (!running_q) begin
                want_first_d     = 1'b1;
                running_d        = 1'b1;
                tempo_deferred_d = 1'b0;
              end
            end
            CMD_SET_TEMPO: begin
              if (running_q) begin
                tempo_deferred_d = 1'b1;
                deferred_tempo_d = clamp_tempo(in_i.tempo_centi_bpm);
              end else begin
                // applied at once while stopped, wait untouched
                current_tempo_d  = clamp_tempo(in_i.tempo_centi_bpm);
                tempo_deferred_d = 1'b0;
                div_for_tick_d   = 1'b0;
                num_d            = NUM_W'(NUMER);
                rem_d            = '0;
                quot_d           = '0;
                cnt_d            = '0;
                state_d          = ST_DIV;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_DIV: begin
        // restoring division, one quotient bit per cycle
        num_d = {num_q[NUM_W-2:0], 1'b0};
        if (alu_y[ALU_W-1]) begin
          rem_d  = div_shift[TEMPO_W-1:0];
          quot_d = {quot_q[PERIOD_W-2:0], 1'b0};
        end else begin
          rem_d  = alu_y[TEMPO_W-1:0];
          quot_d = {quot_q[PERIOD_W-2:0], 1'b1};
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          pulse_period_d   = quot_d;
          tempo_deferred_d = 1'b0;
          if (div_for_tick_q) begin
            pulse_wait_d = WAIT_W'(quot_d);
            state_d      = ST_TICK;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_TICK: begin
        pend_late_d = 1'b0;
        if (want_first_q) begin
          pend_kind_d     = MSG_CLOCK;
          pulse_wait_d    = WAIT_W'(pulse_period_q);
          want_start_d    = 1'b0;
          want_continue_d = 1'b0;
          want_first_d    = 1'b0;
          state_d         = ST_EMIT;
        end else if (want_start_q) begin
          pend_kind_d  = MSG_START;
          want_first_d = 1'b1;
          state_d      = ST_EMIT;
        end else if (want_continue_q) begin
          pend_kind_d  = MSG_CONTINUE;
          want_first_d = 1'b1;
          state_d      = ST_EMIT;
        end else if (want_stop_q) begin
          pend_kind_d = MSG_STOP;
          want_stop_d = 1'b0;
          if (stop_halts_q) begin
            running_d    = 1'b0;
            stop_halts_d = 1'b0;
          end
          state_d = ST_EMIT;
        end else begin
          // count down, saturating very late ticks at the floor
          if (alu_y < WAIT_FLOOR) begin
            pulse_wait_d = WAIT_W'(WAIT_FLOOR);
          end else begin
            pulse_wait_d = WAIT_W'(alu_y);
          end
          state_d = ST_ADD;
        end
      end

      ST_ADD: begin
        if (pulse_wait_q > 0) begin
          state_d = ST_IDLE;
        end else begin
          // fractional remainder carries into the next pulse
          pulse_wait_d = WAIT_W'(alu_y);
          pend_kind_d  = MSG_CLOCK;
          if (alu_y <= 0 && !late_seen_q) begin
            late_seen_d = 1'b1;
            pend_late_d = 1'b1;
          end
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          kind_d      = pend_kind_q;
          late_d      = pend_late_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      running_q        <= 1'b0;
      want_start_q     <= 1'b0;
      want_continue_q  <= 1'b0;
      want_stop_q      <= 1'b0;
      stop_halts_q     <= 1'b0;
      want_first_q     <= 1'b0;
      never_ticked_q   <= 1'b1;
      late_seen_q      <= 1'b0;
      tempo_deferred_q <= 1'b0;
      deferred_tempo_q <= '0;
      current_tempo_q  <= TEMPO_RESET;
      pulse_period_q   <= PERIOD_RESET;
      pulse_wait_q     <= '0;
      div_for_tick_q   <= 1'b0;
      cnt_q            <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q          <= state_d;
      running_q        <= running_d;
      want_start_q     <= want_start_d;
      want_continue_q  <= want_continue_d;
      want_stop_q      <= want_stop_d;
      stop_halts_q     <= stop_halts_d;
      want_first_q     <= want_first_d;
      never_ticked_q   <= never_ticked_d;
      late_seen_q      <= late_seen_d;
      tempo_deferred_q <= tempo_deferred_d;
      deferred_tempo_q <= deferred_tempo_d;
      current_tempo_q  <= current_tempo_d;
      pulse_period_q   <= pulse_period_d;
      pulse_wait_q     <= pulse_wait_d;
      div_for_tick_q   <= div_for_tick_d;
      cnt_q            <= cnt_d;
      out_valid_q      <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    elapsed_q   <= elapsed_d;
    num_q       <= num_d;
    rem_q       <= rem_d;
    quot_q      <= quot_d;
    pend_kind_q <= pend_kind_d;
    pend_late_q <= pend_late_d;
    kind_q      <= kind_d;
    late_q      <= late_d;
  end

endmodule

`default_nettype wire

### dv/midi_clock_generator_test.sv
`default_nettype none

module midi_clock_generator_test;
  import mcg_pkg::*;

  // command code outside the enum, the block drops it
  localparam logic [CMD_W-1:0] CMD_IGNORED = 3'd7;

  localparam int unsigned WATCHDOG_CYCLES = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned HOLD_OFF_AFTER  = 40;
  localparam int unsigned DRAIN_CYCLES    = 64;
  localparam int unsigned RANDOM_ITEMS    = 1150;
  localparam longint      WAIT_FLOOR      = -(longint'(1) << (WAIT_W - 1));

  typedef struct packed {
    msg_e kind;
    logic late;
  } midi_msg_t;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [ELAPSED_W-1:0]  elapsed;
    logic [TEMPO_IN_W-1:0] tempo;
    bit                    typed;
    bit                    has_msg;
    msg_e                  kind;
    logic                  late;
  } transport_row_t;

  logic clk;
  logic rst_n;

  mcg_in_if  in_ch ();
  mcg_out_if out_ch ();

  midi_clock_generator dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // transport state as the block should hold it
  bit                 run_q;
  bit                 start_req;
  bit                 cont_req;
  bit                 stop_req;
  bit                 stop_halts;
  bit                 first_clock_req;
  bit                 tempo_pend;
  bit                 unticked;
  bit                 late_flagged;
  logic [TEMPO_W-1:0] tempo_now;
  logic [TEMPO_W-1:0] tempo_next;
  longint             period_now;
  longint             wait_now;

  midi_msg_t   expected_msgs[$];
  int unsigned mismatches;
  bit          send_burst;

  // directed walk: idle behaviour, extremes of tempo and elapsed time,
  // overlapping transport, deferred tempo, late flag and wait saturation
  transport_row_t directed_rows [0:26] = '{
    '{CMD_TICK,         8'd5,   16'd0,     1'b1, 1'b0, MSG_CLOCK,    1'b0},
    '{CMD_STOP,         8'd0,   16'd0,     1'b0, 1'b0, MSG_CLOCK,    1'b0},
    '{CMD_SET_TEMPO,    8'd0,   16'd0,     1'b0, 1'b0, MSG_CLOCK,    1'b0},
    '{CMD_SET_TEMPO,    8'd0,   16'hffff,  1'b0, 1'b0, MSG_CLOCK,    1'b0},
    '{CMD_IGNORED,      8'hff,  16'hffff,  1'b0, 1'b0, MSG_CLOCK,    1'b0},
    '{CMD_START,        8'd0,   16'd0,     1'b0, 1'b0, MSG_CLOCK,    1'b0},
    '{CMD_START,        8'd0,   16'd0,     1'b0, 1'b0, MSG_CLOCK,    1'b0},
    '{CMD_TICK,         8'd255, 16'd0,     1'b1, 1'b1, MSG_START,    1'b0},
    '{CMD_TICK,         8'd0,   16'd0,     1'b1, 1'b1, MSG_CLOCK,    1'b0},
    '{CMD_TICK,         8'd255, 16'd0,     1'b1, 1'b1, MSG_CLOCK,    1'b1},
    '{CMD_TICK,         8'd255, 16'd0,     1'b1, 1'b1, MSG_CLOCK,    1'b0},
    '{CMD_TICK,         8'd255, 16'd0,     1'b1, 1'b1, MSG_CLOCK,    1'b0},
    '{CMD_SET_TEMPO,    8'd0,   16'd12000, 1'b0, 1'b0, MSG_CLOCK,    1'b0},
    '{CMD_TICK,         8'd0,   16'd0,     1'b1, 1'b0, MSG_CLOCK,    1'b0},
    '{CMD_CONTINUE,     8'd0,   16'd0,     1'b0, 1'b0, MSG_CLOCK,    1'b0},
    '{CMD_STOP,         8'd0,   16'd0,     1'b0, 1'b0, MSG_CLOCK,    1'b0},
    '{CMD_TICK,         8'd7,   16'd0,     1'b1, 1'b1, MSG_CONTINUE, 1'b0},
    '{CMD_TICK,         8'd3,   16'd0,     1'b1, 1'b1, MSG_CLOCK,    1'b0},
    '{CMD_START_CLOCKS, 8'd0,   16'd0,     1'b0, 1'b0, MSG_CLOCK,    1'b0},
    '{CMD_STOP_KEEP,    8'd0,   16'd0,     1'b0, 1'b0, MSG_CLOCK,    1'b0},
    '{CMD_TICK,         8'd1,   16'd0,     1'b1, 1'b1, MSG_STOP,     1'b0},
    '{CMD_TICK,         8'd21,  16'd0,     1'b0, 1'b0, MSG_CLOCK,    1'b0},
    '{CMD_STOP,         8'd0,   16'd0,     1'b0, 1'b0, MSG_CLOCK,    1'b0},
    '{CMD_TICK,         8'd0,   16'd0,     1'b1, 1'b1, MSG_STOP,     1'b0},
    '{CMD_TICK,         8'd9,   16'd0,     1'b1, 1'b0, MSG_CLOCK,    1'b0},
    '{CMD_START_CLOCKS, 8'd0,   16'd0,     1'b0, 1'b0, MSG_CLOCK,    1'b0},
    '{CMD_TICK,         8'd100, 16'd0,     1'b0, 1'b0, MSG_CLOCK,    1'b0}
  };

  function automatic logic [TEMPO_W-1:0] limit_tempo(input logic [TEMPO_IN_W-1:0] t);
    if (t < TEMPO_IN_W'(TEMPO_MIN)) return TEMPO_MIN;
    if (t > TEMPO_IN_W'(TEMPO_MAX)) return TEMPO_MAX;
    return t[TEMPO_W-1:0];
  endfunction

  // tempo is clamped before it gets here
  function void load_tempo(input logic [TEMPO_W-1:0] t);
    tempo_now  = t;
    period_now = longint'(NUMER / longint'(t));
    tempo_pend = 1'b0;
  endfunction

  function void begin_running();
    if (!run_q) begin
      load_tempo(tempo_now);
      run_q = 1'b1;
    end
  endfunction

  function void reset_transport();
    run_q           = 1'b0;
    start_req       = 1'b0;
    cont_req        = 1'b0;
    stop_req        = 1'b0;
    stop_halts      = 1'b0;
    first_clock_req = 1'b0;
    tempo_next      = '0;
    load_tempo(TEMPO_RESET);
    wait_now        = 0;
    unticked        = 1'b1;
    late_flagged    = 1'b0;
  endfunction

  // advances the transport state by one accepted transaction
  function void predict_message(input logic [CMD_W-1:0] cmd, input logic [ELAPSED_W-1:0] el_in,
                                input logic [TEMPO_IN_W-1:0] tp, output bit has,
                                output midi_msg_t msg);
    bit     busy;
    longint el;
    busy = start_req || cont_req || stop_req;
    has  = 1'b0;
    msg  = '{MSG_CLOCK, 1'b0};
    el   = longint'(el_in);
    case (cmd)
      CMD_START: begin
        if (!busy) begin
          start_req = 1'b1;
          begin_running();
        end
      end
      CMD_CONTINUE: begin
        if (!busy) begin
          cont_req = 1'b1;
          begin_running();
        end
      end
      CMD_STOP, CMD_STOP_KEEP: begin
        if (!busy && run_q) begin
          stop_req   = 1'b1;
          stop_halts = (cmd == CMD_STOP);
        end
      end
      CMD_START_CLOCKS: begin
        if (!run_q) begin
          first_clock_req = 1'b1;
          begin_running();
        end
      end
      CMD_SET_TEMPO: begin
        if (run_q) begin
          tempo_pend = 1'b1;
          tempo_next = limit_tempo(tp);
        end else begin
          load_tempo(limit_tempo(tp));
        end
      end
      CMD_TICK: begin
        if (run_q) begin
          // first tick while running ignores its elapsed time
          if (unticked) begin
            if (!first_clock_req && !busy) first_clock_req = 1'b1;
            unticked = 1'b0;
            el = 0;
          end
          if (tempo_pend) begin
            load_tempo(tempo_next);
            wait_now = period_now;
          end
          if (first_clock_req) begin
            has             = 1'b1;
            msg.kind        = MSG_CLOCK;
            wait_now        = period_now;
            start_req       = 1'b0;
            cont_req        = 1'b0;
            first_clock_req = 1'b0;
          end else if (start_req) begin
            has             = 1'b1;
            msg.kind        = MSG_START;
            first_clock_req = 1'b1;
          end else if (cont_req) begin
            has             = 1'b1;
            msg.kind        = MSG_CONTINUE;
            first_clock_req = 1'b1;
          end else if (stop_req) begin
            has      = 1'b1;
            msg.kind = MSG_STOP;
            stop_req = 1'b0;
            if (stop_halts) begin
              run_q      = 1'b0;
              stop_halts = 1'b0;
            end
          end else begin
            wait_now = wait_now - (el <<< FRACTION_BITS);
            if (wait_now < WAIT_FLOOR) wait_now = WAIT_FLOOR;
            if (wait_now <= 0) begin
              wait_now = wait_now + period_now;
              has      = 1'b1;
              msg.kind = MSG_CLOCK;
              if (wait_now <= 0 && !late_flagged) begin
                late_flagged = 1'b1;
                msg.late     = 1'b1;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_message(input logic [KIND_W-1:0] kind, input logic late);
    midi_msg_t want;
    if (expected_msgs.size() == 0) begin
      report_mismatch("message with none pending", int'(kind), -1);
    end else begin
      want = expected_msgs.pop_front();
      if (kind !== want.kind) report_mismatch("message_kind", int'(kind), int'(want.kind));
      if (late !== want.late) report_mismatch("late_warning", int'(late), int'(want.late));
    end
  endtask

  // offers one transaction after a random gap and books its expected message
  task automatic send_transaction(input logic [CMD_W-1:0] cmd, input logic [ELAPSED_W-1:0] el,
                                  input logic [TEMPO_IN_W-1:0] tp, input bit typed,
                                  input bit typed_has, input midi_msg_t typed_msg);
    int unsigned gap;
    bit          has;
    midi_msg_t   msg;
    gap = send_burst ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.command         <= cmd;
    in_ch.elapsed_ms      <= el;
    in_ch.tempo_centi_bpm <= tp;
    do @(posedge clk); while (!in_ch.ready);
    predict_message(cmd, el, tp, has, msg);
    if (typed) begin
      has = typed_has;
      msg = typed_msg;
    end
    if (has) expected_msgs.push_back(msg);
  endtask

  // mostly ticks with short gaps while running, enough starts to keep it running,
  // plus tempo changes and stray transport
  task automatic random_transaction(output logic [CMD_W-1:0] cmd,
                                    output logic [ELAPSED_W-1:0] el,
                                    output logic [TEMPO_IN_W-1:0] tp);
    int unsigned pick;
    int unsigned shape;
    pick = $urandom_range(0, 99);
    if (!run_q && pick < 40) begin
      case ($urandom_range(0, 2))
        0:       cmd = CMD_START;
        1:       cmd = CMD_CONTINUE;
        default: cmd = CMD_START_CLOCKS;
      endcase
    end else if (pick < 60) cmd = CMD_TICK;
    else if (pick < 65) cmd = CMD_START;
    else if (pick < 69) cmd = CMD_CONTINUE;
    else if (pick < 74) cmd = CMD_STOP;
    else if (pick < 79) cmd = CMD_STOP_KEEP;
    else if (pick < 83) cmd = CMD_START_CLOCKS;
    else if (pick < 97) cmd = CMD_SET_TEMPO;
    else cmd = CMD_IGNORED;

    shape = $urandom_range(0, 9);
    if (shape < 7) el = ELAPSED_W'($urandom_range(0, 30));
    else if (shape < 9) el = ELAPSED_W'($urandom_range(0, 255));
    else el = ELAPSED_W'($urandom_range(200, 255));

    shape = $urandom_range(0, 9);
    if (shape < 5) tp = TEMPO_IN_W'($urandom_range(0, 65535));
    else if (shape < 9) tp = TEMPO_IN_W'($urandom_range(1000, 30000));
    else begin
      case ($urandom_range(0, 5))
        0:       tp = 16'd0;
        1:       tp = 16'd999;
        2:       tp = 16'd1000;
        3:       tp = 16'd30000;
        4:       tp = 16'd30001;
        default: tp = 16'hffff;
      endcase
    end
  endtask

  initial begin : stimulus
    logic [CMD_W-1:0]      cmd;
    logic [ELAPSED_W-1:0]  el;
    logic [TEMPO_IN_W-1:0] tp;
    int unsigned           counted;
    int unsigned           issued;
    mismatches             = 0;
    send_burst             = 1'b0;
    counted                = 0;
    issued                 = 0;
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.command         <= CMD_TICK;
    in_ch.elapsed_ms      <= '0;
    in_ch.tempo_centi_bpm <= '0;
    reset_transport();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_transaction(directed_rows[i].cmd, directed_rows[i].elapsed, directed_rows[i].tempo,
                       directed_rows[i].typed, directed_rows[i].has_msg,
                       '{directed_rows[i].kind, directed_rows[i].late});
    end

    while (counted < RANDOM_ITEMS) begin
      // halfway through, let the pipeline drain completely once
      if (issued == RANDOM_ITEMS / 2) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_msgs.size() != 0);
      end
      if (issued % 50 == 0) send_burst = ($urandom_range(0, 2) == 0);
      random_transaction(cmd, el, tp);
      // dropped codes and ticks while stopped do not count
      if (!(cmd == CMD_IGNORED || (cmd == CMD_TICK && !run_q))) counted++;
      send_transaction(cmd, el, tp, 1'b0, 1'b0, '{MSG_CLOCK, 1'b0});
      issued++;
    end
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (expected_msgs.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("midi_clock_generator test passed");
    end else begin
      $display("midi_clock_generator test failed");
    end
    $finish;
  end

  // receiver: random stalls, bursts without stalls, one long hold-off
  initial begin : message_sink
    int unsigned stall;
    int unsigned taken;
    bit          burst;
    bit          held;
    taken = 0;
    burst = 1'b0;
    held  = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken % 32 == 0) burst = ($urandom_range(0, 2) == 0);
      if (taken == HOLD_OFF_AFTER && !held) begin
        stall = HOLD_OFF_CYCLES;
        held  = 1'b1;
      end else begin
        stall = burst ? 0 : $urandom_range(0, 9);
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      check_message(out_ch.message_kind, out_ch.late_warning);
      taken++;
    end
  end

  // ends the run once neither channel has moved a transaction for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("midi_clock_generator test failed");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/mcg_pkg.sv
rtl/mcg_in_if.sv
rtl/mcg_out_if.sv
rtl/mcg_alu.sv
rtl/midi_clock_generator.sv
dv/midi_clock_generator_test.sv
